[rtl/error_diffusion_dither_rgb555_top_defines.svh]
// ----------------------------------------------------------------------------
// Error diffusion dither assertion macros
// Shared concurrent assertion forms, clocked on i_clk and masked during reset.
// ----------------------------------------------------------------------------
`ifndef ERROR_DIFFUSION_DITHER_RGB555_TOP_DEFINES_SVH
`define ERROR_DIFFUSION_DITHER_RGB555_TOP_DEFINES_SVH

// Same-cycle implication.
`define EDD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("edd: same-cycle check failed");

// Next-cycle implication.
`define EDD_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("edd: next-cycle check failed");

`endif

[rtl/edd_pkg.sv]
// ----------------------------------------------------------------------------
// Error diffusion dither package
// Widths, register indexes and the structs shared by the dither modules.
// ----------------------------------------------------------------------------
package edd_pkg;

    localparam int NUM_CHAN    = 3;
    localparam int PIX_W       = 8;
    localparam int Q_W         = 5;
    localparam int ERR_W       = 8;
    localparam int WORD_W      = NUM_CHAN * Q_W;
    localparam int WIDTH_REG_W = 13;
    localparam int HEIGHT_W    = 16;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;
    localparam int OQ_DEPTH    = 4;
    localparam int OQ_CNT_W    = $clog2(OQ_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

    localparam logic [WIDTH_REG_W-1:0] RESET_IMAGE_WIDTH  = 13'd640;
    localparam logic [HEIGHT_W-1:0]    RESET_IMAGE_HEIGHT = 16'd480;

    typedef logic signed [ERR_W-1:0] t_err;

    // Quantized code of one channel and its weighted error terms.
    typedef struct packed {
        logic [Q_W-1:0] q;
        t_err           e1;
        t_err           e3;
        t_err           e5;
        t_err           e7;
    } t_chan_res;

    typedef struct packed {
        logic [WORD_W-1:0] pixel_word;
        logic              row_end;
        logic              frame_end;
    } t_out_item;

    typedef struct packed {
        logic                valid;
        logic [OQ_CNT_W-1:0] count;
    } t_oq_stat;

endpackage

[rtl/edd_ram.sv]
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module edd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // A read at the address being written returns the old contents.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/edd_chan.sv]
// ----------------------------------------------------------------------------
// Error diffusion dither channel quantizer
// Adds the diffused error to one color byte, clamps, quantizes to five bits
// and forms the weighted error terms for the neighbors.
// ----------------------------------------------------------------------------
module edd_chan (
    input  logic [edd_pkg::PIX_W-1:0] i_pixel,
    input  edd_pkg::t_err             i_row_err,
    input  edd_pkg::t_err             i_carry,
    output edd_pkg::t_chan_res        o_res
);

    // floor(q*255/31) equals 8*q plus this small correction.
    function automatic logic [2:0] level_frac(input logic [4:0] q);
        logic [2:0] f;
        f = {2'b00, q >= 5'd5}  + {2'b00, q >= 5'd9}  + {2'b00, q >= 5'd14} +
            {2'b00, q >= 5'd18} + {2'b00, q >= 5'd23} + {2'b00, q >= 5'd27} +
            {2'b00, q >= 5'd31};
        return f;
    endfunction

    logic signed [8:0] acc;
    logic signed [8:0] acc_adj;
    logic signed [8:0] quo;
    logic signed [9:0] sum;
    logic [7:0]        sat;
    logic [4:0]        q;
    logic [2:0]        frac;
    logic signed [4:0] e;
    edd_pkg::t_err     e8;

    always_comb begin
        acc     = {i_row_err[7], i_row_err} + {i_carry[7], i_carry};
        // Division by 16 that truncates toward zero.
        acc_adj = acc[8] ? (acc + 9'sd15) : acc;
        quo     = acc_adj >>> 4;
        sum     = $signed({2'b00, i_pixel}) + $signed({quo[8], quo});
        if (sum[9]) begin
            sat = 8'd0;
        end else if (sum[8]) begin
            sat = 8'hff;
        end else begin
            sat = sum[7:0];
        end
        q    = sat[7:3];
        frac = level_frac(q);
        e    = $signed({2'b00, sat[2:0]}) - $signed({2'b00, frac});
        e8   = {{3{e[4]}}, e};
    end

    assign o_res.q  = q;
    assign o_res.e1 = e8;
    assign o_res.e3 = (e8 <<< 1) + e8;
    assign o_res.e5 = (e8 <<< 2) + e8;
    assign o_res.e7 = (e8 <<< 3) - e8;

endmodule

[rtl/edd_outq.sv]
// ----------------------------------------------------------------------------
// Error diffusion dither output queue
// Small register queue that decouples result delivery from the pixel pipe.
// ----------------------------------------------------------------------------
`include "error_diffusion_dither_rgb555_top_defines.svh"

module edd_outq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  edd_pkg::t_out_item i_item,
    input  logic               i_pop,
    output edd_pkg::t_out_item o_item,
    output edd_pkg::t_oq_stat  o_stat
);

    localparam int PW = $clog2(edd_pkg::OQ_DEPTH);

    edd_pkg::t_out_item            r_mem [edd_pkg::OQ_DEPTH];
    logic [PW-1:0]                 r_wptr;
    logic [PW-1:0]                 r_rptr;
    logic [edd_pkg::OQ_CNT_W-1:0]  r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + PW'(1);
            end
            if (i_pop) begin
                r_rptr <= r_rptr + PW'(1);
            end
            case ({i_push, i_pop})
                2'b10: begin
                    r_count <= r_count + edd_pkg::OQ_CNT_W'(1);
                end
                2'b01: begin
                    r_count <= r_count - edd_pkg::OQ_CNT_W'(1);
                end
                default: begin
                    r_count <= r_count;
                end
            endcase
        end
    end

    assign o_item       = r_mem[r_rptr];
    assign o_stat.valid = (r_count != '0);
    assign o_stat.count = r_count;

    `EDD_ASSERT_IMP(a_oq_no_overflow, i_push && !i_pop, r_count < edd_pkg::OQ_CNT_W'(edd_pkg::OQ_DEPTH))

endmodule

[rtl/error_diffusion_dither_rgb555_top.sv]
// ----------------------------------------------------------------------------
// Error diffusion dither, RGB888 to RGB555
// Top level: position counters, line buffer control, channel quantizers and
// the output queue.
// ----------------------------------------------------------------------------
// This block dithers a raster stream of 24-bit pixels down to packed RGB555
// words, spreading each channel's quantization error 7/16 to the right, and
// 3/16, 5/16 and 1/16 to the lower-left, lower and lower-right neighbors. It
// takes one pixel transaction per clock and delivers one result transaction per
// clock unless a stall holds it; a result is registered in stage 1 and then in
// the output queue. The rate is set by the single line buffer, which serves
// one read (this row's error for the pixel's column) and one write (the final
// next-row error for the column to the left) every clock. Errors for the next
// row are built up in registers and written back behind the read pointer, so
// one memory of MAX_WIDTH entries holds both the current and the next row.
// Writes still in flight are forwarded to the read, and a fill count marks how
// many columns the previous row left in the buffer, so no clearing pass is
// needed after reset or at the end of a frame. A four-entry output queue lets
// the block keep taking pixels while results wait; the input stalls only when
// that queue cannot take what is already in flight. The image width and height
// registers may be written between frames or while the stream is idle; a
// narrower width or lower height takes effect at the current position.
// ----------------------------------------------------------------------------
`include "error_diffusion_dither_rgb555_top_defines.svh"

module error_diffusion_dither_rgb555_top #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Configuration write channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [edd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [edd_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    // Pixel input channel
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [edd_pkg::PIX_W-1:0]       i_chan0,
    input  logic [edd_pkg::PIX_W-1:0]       i_chan1,
    input  logic [edd_pkg::PIX_W-1:0]       i_chan2,
    // Result output channel
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [edd_pkg::WORD_W-1:0]      o_pixel_word,
    output logic                            o_row_end,
    output logic                            o_frame_end
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int FW = CW + 1;
    localparam int WW = (FW > edd_pkg::WIDTH_REG_W) ? FW : edd_pkg::WIDTH_REG_W;
    localparam int EW = edd_pkg::ERR_W;
    localparam int MW = edd_pkg::NUM_CHAN * EW;
    localparam int HW = edd_pkg::HEIGHT_W;

    // One line buffer write: the column and its three channel error sums.
    typedef struct packed {
        logic          vld;
        logic [CW-1:0] addr;
        logic [MW-1:0] data;
    } t_wr_rec;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [edd_pkg::WIDTH_REG_W-1:0] r_image_width;
    logic [HW-1:0]                   r_image_height;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= edd_pkg::RESET_IMAGE_WIDTH;
            r_image_height <= edd_pkg::RESET_IMAGE_HEIGHT;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                edd_pkg::CFG_IMAGE_WIDTH: begin
                    r_image_width <= i_cfg_wdata[edd_pkg::WIDTH_REG_W-1:0];
                end
                edd_pkg::CFG_IMAGE_HEIGHT: begin
                    r_image_height <= i_cfg_wdata[HW-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Accept stage: position in the frame and the line buffer read
    // ------------------------------------------------------------------
    logic          s0_accept;
    logic          s0_row_end;
    logic          s0_last_row;
    logic [WW-1:0] w_ext;
    logic [WW-1:0] w_eff;
    logic [HW-1:0] h_last;
    logic [CW-1:0] r_col;
    logic [HW-1:0] r_row;

    assign s0_accept = i_in_valid && !o_in_stall;

    // A width of zero acts as one, and a width above the buffer as the buffer.
    always_comb begin
        w_ext = WW'(r_image_width);
        if (w_ext == '0) begin
            w_eff = WW'(1);
        end else if (w_ext > WW'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = w_ext;
        end
        h_last = (r_image_height == '0) ? '0 : (r_image_height - HW'(1));
    end

    assign s0_row_end  = (WW'(r_col) >= (w_eff - WW'(1)));
    assign s0_last_row = (r_row >= h_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (s0_accept) begin
            if (s0_row_end) begin
                r_col <= '0;
                r_row <= s0_last_row ? '0 : (r_row + HW'(1));
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    // Stage 1 holds the accepted pixel while its line buffer read returns.
    logic                        r_s1_vld;
    logic [CW-1:0]               r_s1_col;
    logic                        r_s1_re;
    logic                        r_s1_lr;
    logic [edd_pkg::PIX_W-1:0]   r_s1_chan [edd_pkg::NUM_CHAN];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= s0_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s0_accept) begin
            r_s1_col     <= r_col;
            r_s1_re      <= s0_row_end;
            r_s1_lr      <= s0_last_row;
            r_s1_chan[0] <= i_chan0;
            r_s1_chan[1] <= i_chan1;
            r_s1_chan[2] <= i_chan2;
        end
    end

    // ------------------------------------------------------------------
    // Line buffer with write forwarding
    // ------------------------------------------------------------------
    t_wr_rec       r_wr;   // write presented to the buffer this cycle
    t_wr_rec       r_wc;   // write committed at the edge of the current read
    t_wr_rec       r_pd;   // second write of a row end, waiting for the port
    t_wr_rec       n_wr;
    t_wr_rec       n_pd;
    t_wr_rec       wa;
    t_wr_rec       wb;
    logic [MW-1:0] ram_rdata;
    logic [MW-1:0] row_data;
    logic [MW-1:0] row_err_word;
    logic [MW-1:0] wa_word;
    logic [MW-1:0] wb_word;
    logic [FW-1:0] r_fill;
    logic          in_fill;

    edd_ram #(
        .WIDTH (MW),
        .DEPTH (MAX_WIDTH)
    ) u_line_buf (
        .i_clk   (i_clk),
        .i_we    (r_wr.vld),
        .i_waddr (r_wr.addr),
        .i_wdata (r_wr.data),
        .i_re    (s0_accept),
        .i_raddr (r_col),
        .o_rdata (ram_rdata)
    );

    // The newest pending write to the column wins over older ones and over
    // the buffer contents. Columns beyond what the previous row wrote read
    // as zero, which also covers the first row of every frame.
    always_comb begin
        if (r_pd.vld && (r_pd.addr == r_s1_col)) begin
            row_data = r_pd.data;
        end else if (r_wr.vld && (r_wr.addr == r_s1_col)) begin
            row_data = r_wr.data;
        end else if (r_wc.vld && (r_wc.addr == r_s1_col)) begin
            row_data = r_wc.data;
        end else begin
            row_data = ram_rdata;
        end
        in_fill      = ({1'b0, r_s1_col} < r_fill);
        row_err_word = in_fill ? row_data : '0;
    end

    // Each pixel finalizes the next-row sum of the column to its left; a row
    // end also finalizes its own column, so two writes may arise at once. The
    // pixel after a row end sits at column zero with no left column to write,
    // which leaves the port free for the second one. Pixels of a last row
    // pass no error downward but still write their column, so a height raised
    // in the middle of a row never leaves stale sums for the row below.
    always_comb begin
        wa.vld  = r_s1_vld && (r_s1_col != '0);
        wa.addr = r_s1_col - CW'(1);
        wa.data = wa_word;
        wb.vld  = r_s1_vld && !r_s1_lr && r_s1_re;
        wb.addr = r_s1_col;
        wb.data = wb_word;
        n_wr    = '0;
        n_pd    = '0;
        if (r_pd.vld) begin
            n_wr = r_pd;
            if (wa.vld) begin
                n_pd = wa;
            end else if (wb.vld) begin
                n_pd = wb;
            end
        end else if (wa.vld) begin
            n_wr = wa;
            if (wb.vld) begin
                n_pd = wb;
            end
        end else if (wb.vld) begin
            n_wr = wb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_wc   <= '0;
            r_pd   <= '0;
            r_fill <= '0;
        end else begin
            r_wr <= n_wr;
            r_wc <= r_wr;
            r_pd <= n_pd;
            if (r_s1_vld && r_s1_re) begin
                r_fill <= r_s1_lr ? '0 : (FW'(r_s1_col) + FW'(1));
            end
        end
    end

    // ------------------------------------------------------------------
    // Channel lanes: quantize, then carry the error right and downward
    // ------------------------------------------------------------------
    logic [edd_pkg::WORD_W-1:0] pix_word;

    for (genvar k = 0; k < edd_pkg::NUM_CHAN; k++) begin : g_ch
        edd_pkg::t_err      r_carry;  // 7e from the pixel to the left
        edd_pkg::t_err      r_nb;     // next-row sum for the column to the left
        edd_pkg::t_err      r_na;     // next-row sum for this column
        edd_pkg::t_chan_res res;
        edd_pkg::t_err      dn_e1;    // downward terms, zero on a last row
        edd_pkg::t_err      dn_e3;
        edd_pkg::t_err      dn_e5;

        edd_chan u_chan (
            .i_pixel   (r_s1_chan[k]),
            .i_row_err (row_err_word[k*EW +: EW]),
            .i_carry   (r_carry),
            .o_res     (res)
        );

        assign dn_e1 = r_s1_lr ? '0 : res.e1;
        assign dn_e3 = r_s1_lr ? '0 : res.e3;
        assign dn_e5 = r_s1_lr ? '0 : res.e5;

        assign wa_word[k*EW +: EW] = r_nb + dn_e3;
        assign wb_word[k*EW +: EW] = r_na + dn_e5;
        assign pix_word[k*edd_pkg::Q_W +: edd_pkg::Q_W] = res.q;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_carry <= '0;
                r_nb    <= '0;
                r_na    <= '0;
            end else if (r_s1_vld) begin
                r_carry <= r_s1_re ? '0 : res.e7;
                r_nb    <= r_s1_re ? '0 : (r_na + dn_e5);
                r_na    <= r_s1_re ? '0 : dn_e1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output queue
    // ------------------------------------------------------------------
    edd_pkg::t_out_item oq_in;
    edd_pkg::t_out_item oq_out;
    edd_pkg::t_oq_stat  oq_stat;
    logic               oq_pop;
    logic [edd_pkg::OQ_CNT_W:0] occupancy;

    assign oq_in.pixel_word = pix_word;
    assign oq_in.row_end    = r_s1_re;
    assign oq_in.frame_end  = r_s1_re && r_s1_lr;
    assign oq_pop           = oq_stat.valid && !i_out_stall;

    edd_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_s1_vld),
        .i_item  (oq_in),
        .i_pop   (oq_pop),
        .o_item  (oq_out),
        .o_stat  (oq_stat)
    );

    // Count the pixel in stage 1 as already queued.
    assign occupancy  = {1'b0, oq_stat.count} + (edd_pkg::OQ_CNT_W + 1)'(r_s1_vld);
    assign o_in_stall = (occupancy >= (edd_pkg::OQ_CNT_W + 1)'(edd_pkg::OQ_DEPTH));

    assign o_out_valid  = oq_stat.valid;
    assign o_pixel_word = oq_out.pixel_word;
    assign o_row_end    = oq_out.row_end;
    assign o_frame_end  = oq_out.frame_end;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `EDD_ASSERT_IMP(a_pend_at_col0, r_pd.vld && r_s1_vld, r_s1_col == '0)
    `EDD_ASSERT_NXT(a_frame_pos_clear, s0_accept && s0_row_end && s0_last_row, r_col == '0 && r_row == '0)
    `EDD_ASSERT_NXT(a_frame_fill_clear, r_s1_vld && r_s1_re && r_s1_lr, r_fill == '0 && !r_pd.vld)

endmodule

[dv/edd_tb_pkg.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Error diffusion dither scoreboard
// Keeps its own copy of the line error stores, the right carry, the frame
// position and the geometry registers, predicts the RGB555 word with its row
// and frame flags for every pixel taken, and checks results in order.
// ----------------------------------------------------------------------------
package edd_tb_pkg;

    import edd_pkg::*;

    localparam int MAX_WIDTH    = 4096;
    localparam int REPORT_LIMIT = 10;

    class dither_scoreboard;
        logic [WIDTH_REG_W-1:0] image_width;
        logic [HEIGHT_W-1:0]    image_height;
        int                     row_err     [MAX_WIDTH][NUM_CHAN];
        int                     next_err    [MAX_WIDTH][NUM_CHAN];
        int                     right_carry [NUM_CHAN];
        int unsigned            column;
        int unsigned            row;
        t_out_item              pending_words [$];
        int unsigned            failures;

        function new();
            image_width  = RESET_IMAGE_WIDTH;
            image_height = RESET_IMAGE_HEIGHT;
            failures     = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            foreach (row_err[c, k]) begin
                row_err[c][k]  = 0;
                next_err[c][k] = 0;
            end
            foreach (right_carry[k]) right_carry[k] = 0;
            column = 0;
            row    = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
            if (index == CFG_IMAGE_WIDTH) begin
                image_width = data[WIDTH_REG_W-1:0];
            end else if (index == CFG_IMAGE_HEIGHT) begin
                image_height = data[HEIGHT_W-1:0];
            end
        endfunction

        // Width as the block applies it: zero acts as one, oversize as the maximum.
        function int unsigned active_width();
            int unsigned w;
            w = image_width;
            if (w == 0) w = 1;
            if (w > MAX_WIDTH) w = MAX_WIDTH;
            return w;
        endfunction

        function void note_pixel(logic [PIX_W-1:0] c0, logic [PIX_W-1:0] c1,
                                 logic [PIX_W-1:0] c2);
            logic [PIX_W-1:0] chan [NUM_CHAN];
            int unsigned      w;
            int unsigned      h;
            bit               row_end;
            bit               last_row;
            int               s;
            int               e;
            logic [Q_W-1:0]   q;
            t_out_item        item;
            chan[0] = c0;
            chan[1] = c1;
            chan[2] = c2;
            w = active_width();
            h = image_height;
            if (h == 0) h = 1;
            row_end  = (column >= w - 1);
            last_row = (row >= h - 1);
            item.pixel_word = '0;
            for (int k = 0; k < NUM_CHAN; k++) begin
                s = int'(chan[k]) + (row_err[column][k] + right_carry[k]) / 16;
                if (s < 0) s = 0;
                if (s > 255) s = 255;
                q = s[7:3];
                e = s - (int'(q) * 255) / 31;
                item.pixel_word[k*Q_W +: Q_W] = q;
                right_carry[k] = row_end ? 0 : 7 * e;
                if (!last_row) begin
                    if (column >= 1) next_err[column-1][k] += 3 * e;
                    next_err[column][k] += 5 * e;
                    if (!row_end) next_err[column+1][k] += e;
                end
            end
            item.row_end   = row_end;
            item.frame_end = row_end && last_row;
            pending_words.push_back(item);

            if (!row_end) begin
                column++;
            end else if (last_row) begin
                clear_frame();
            end else begin
                row_err = next_err;
                foreach (next_err[c, k]) next_err[c][k] = 0;
                column = 0;
                row++;
            end
        endfunction

        function void check_word(logic [WORD_W-1:0] pixel_word, logic row_end,
                                 logic frame_end);
            t_out_item want;
            if (pending_words.size() == 0) begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("dither: unexpected result word=%h row_end=%b frame_end=%b",
                             pixel_word, row_end, frame_end);
                return;
            end
            want = pending_words.pop_front();
            if (want.pixel_word !== pixel_word || want.row_end !== row_end ||
                want.frame_end !== frame_end) begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("dither: expected word=%h re=%b fe=%b, got word=%h re=%b fe=%b",
                             want.pixel_word, want.row_end, want.frame_end,
                             pixel_word, row_end, frame_end);
            end
        endfunction
    endclass

endpackage

[dv/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Error diffusion dither regression bench
// Streams pixels through the RGB888 to RGB555 dither under random pacing on
// both channels, reprograms the frame geometry between idle phases and checks
// every result word and its row and frame flags against a scoreboard.
// ----------------------------------------------------------------------------
module tb;

    import edd_pkg::*;
    import edd_tb_pkg::*;

    localparam int RANDOM_ITEMS = 850;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int TAIL_CYCLES  = 16;
    localparam int LONG_HOLD    = 120;
    localparam int TAIL_WIDTH   = 128;

    // Pacing styles shared by the pixel sender and the result receiver.
    typedef enum int {
        PACE_FREE,
        PACE_LIGHT,
        PACE_HEAVY
    } t_pace;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_wdata;
    logic                   i_in_valid;
    logic                   o_in_stall;
    logic [PIX_W-1:0]       i_chan0;
    logic [PIX_W-1:0]       i_chan1;
    logic [PIX_W-1:0]       i_chan2;
    logic                   o_out_valid;
    logic                   i_out_stall = 1'b0;
    logic [WORD_W-1:0]      o_pixel_word;
    logic                   o_row_end;
    logic                   o_frame_end;

    dither_scoreboard       sb;
    t_pace                  send_pace;
    t_pace                  recv_pace;
    int unsigned            recv_stall_left;
    int unsigned            recv_stretch_left;
    int unsigned            recv_hold_request;
    int unsigned            cycle_count;

    error_diffusion_dither_rgb555_top #(
        .MAX_WIDTH(MAX_WIDTH)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_chan0      (i_chan0),
        .i_chan1      (i_chan1),
        .i_chan2      (i_chan2),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_pixel_word (o_pixel_word),
        .o_row_end    (o_row_end),
        .o_frame_end  (o_frame_end)
    );

    // 2 ns clock: rising edges at odd nanoseconds, falling edges at even ones.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Idle cycles before the next pixel. Most gaps are short; the heavy style
    // adds an occasional long one so gaps land on every phase of the pipeline.
    function automatic int unsigned pick_gap(t_pace pace);
        int unsigned r;
        r = $urandom_range(0, 99);
        case (pace)
            PACE_FREE:  return 0;
            PACE_LIGHT: return (r < 80) ? 0 : $urandom_range(1, 3);
            default: begin
                if (r < 50) return 0;
                if (r < 90) return $urandom_range(1, 4);
                return $urandom_range(8, 30);
            end
        endcase
    endfunction

    // Channel value biased toward the saturation and rounding corners: 248
    // leaves the most negative error, 7 the most positive, 0 and 255 clamp.
    function automatic logic [PIX_W-1:0] pick_level();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 8)  return 8'd0;
        if (r < 16) return 8'd255;
        if (r < 22) return 8'd248;
        if (r < 26) return 8'd7;
        return PIX_W'($urandom_range(0, 255));
    endfunction

    // Offer one pixel after a pacing gap and hold it until the block takes it.
    // Inputs change on the falling edge; the handshake is judged on the rising
    // edge, where the scoreboard learns about the accepted transaction.
    task automatic send_rgb(input logic [PIX_W-1:0] c0, input logic [PIX_W-1:0] c1,
                            input logic [PIX_W-1:0] c2);
        int unsigned gap;
        gap = pick_gap(send_pace);
        repeat (gap) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
        end
        @(negedge i_clk);
        i_in_valid = 1'b1;
        i_chan0    = c0;
        i_chan1    = c1;
        i_chan2    = c2;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_pixel(c0, c1, c2);
    endtask

    // Stop offering pixels and wait until every predicted result has been seen.
    // The check is made on the falling edge, after the result monitor has run.
    task automatic drain_outputs();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (sb.pending_words.size() != 0) @(negedge i_clk);
    endtask

    // One register write transaction; only issued while the block is idle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = index;
        i_cfg_wdata = data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.set_register(index, data);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Result receiver. It runs in stretches of one pacing style, and a hold-off
    // request from the stimulus turns into a long stall counted here, so the
    // output queue fills and the block has to stall its pixel input.
    always begin
        @(negedge i_clk);
        if (recv_hold_request != 0) begin
            recv_stall_left   = recv_hold_request;
            recv_hold_request = 0;
        end
        if (recv_stall_left == 0) begin
            if (recv_stretch_left == 0) begin
                recv_pace         = t_pace'($urandom_range(0, 2));
                recv_stretch_left = $urandom_range(50, 300);
            end
            recv_stretch_left--;
            case (recv_pace)
                PACE_FREE: recv_stall_left = 0;
                PACE_LIGHT: begin
                    if ($urandom_range(0, 99) < 10) recv_stall_left = $urandom_range(1, 3);
                end
                default: begin
                    if ($urandom_range(0, 99) < 30) begin
                        recv_stall_left = ($urandom_range(0, 19) == 0) ?
                                          $urandom_range(15, 40) : $urandom_range(1, 4);
                    end
                end
            endcase
        end
        if (recv_stall_left != 0) begin
            i_out_stall = 1'b1;
            recv_stall_left--;
        end else begin
            i_out_stall = 1'b0;
        end
    end

    // Every result transaction goes to the scoreboard in arrival order.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_word(o_pixel_word, o_row_end, o_frame_end);
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("error_diffusion_dither_rgb555_top regression: fail");
        $finish;
    end

    initial begin
        int unsigned           random_items;
        int unsigned           phase_items;
        int unsigned           tail_items;
        int unsigned           r;
        bit                    first_phase;
        logic [CFG_DATA_W-1:0] width_val;
        logic [CFG_DATA_W-1:0] height_val;

        sb                = new();
        i_rst_n           = 1'b0;
        i_cfg_valid       = 1'b0;
        i_cfg_index       = CFG_IMAGE_WIDTH;
        i_cfg_wdata       = '0;
        i_in_valid        = 1'b0;
        i_chan0           = '0;
        i_chan1           = '0;
        i_chan2           = '0;
        send_pace         = PACE_FREE;
        recv_pace         = PACE_FREE;
        recv_stall_left   = 0;
        recv_stretch_left = 0;
        recv_hold_request = 0;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part, at the reset geometry of 640 by 480. The pixel at 248
        // leaves an error of -7, so the black pixel after it sees a negative
        // sum that must clamp to zero. The pixel at 7 leaves +7, which pushes
        // the white pixel after it past 255.
        send_rgb(8'd248, 8'd248, 8'd248);
        send_rgb(8'd0,   8'd0,   8'd0);
        send_rgb(8'd7,   8'd7,   8'd7);
        send_rgb(8'd255, 8'd255, 8'd255);
        send_rgb(8'd0,   8'd255, 8'd0);
        send_rgb(8'd255, 8'd0,   8'd255);
        send_rgb(8'hAA,  8'h55,  8'hF0);
        send_rgb(8'h0F,  8'h80,  8'h01);

        // Shrink the frame to 3 by 2 in the middle of a row. The column is
        // already past the new width, so the next pixel must end the row, and
        // the following row is the last one of the frame.
        drain_outputs();
        write_reg(CFG_IMAGE_WIDTH, 16'd3);
        write_reg(CFG_IMAGE_HEIGHT, 16'd2);
        send_rgb(8'd248, 8'd7,   8'd128);
        send_rgb(8'd7,   8'd248, 8'd0);
        send_rgb(8'd248, 8'd0,   8'd255);
        send_rgb(8'd0,   8'd255, 8'd248);

        // A whole 3 by 2 frame, so errors travel down and to both diagonals.
        send_rgb(8'd248, 8'd248, 8'd7);
        send_rgb(8'd0,   8'd248, 8'd7);
        send_rgb(8'd248, 8'd0,   8'd7);
        send_rgb(8'd0,   8'd0,   8'd0);
        send_rgb(8'd255, 8'd0,   8'd255);
        send_rgb(8'd0,   8'd255, 8'd0);

        // Zero width and zero height act as one: every pixel closes a frame.
        // The width is written with only its upper, ignored bits set.
        drain_outputs();
        write_reg(CFG_IMAGE_WIDTH, 16'hE000);
        write_reg(CFG_IMAGE_HEIGHT, 16'd0);
        send_rgb(8'd248, 8'd248, 8'd248);
        send_rgb(8'd0,   8'd0,   8'd0);
        send_rgb(8'd255, 8'd7,   8'd248);

        // Random phases. Each one starts from an idle block with a new geometry,
        // which keeps the frame position, so lowered limits end rows and frames
        // early. The first phase runs the sender flat out against a long
        // receiver hold-off to fill the block up.
        random_items = 0;
        first_phase  = 1'b1;
        while (random_items < RANDOM_ITEMS) begin
            drain_outputs();
            r = $urandom_range(0, 99);
            if (r < 5)       width_val = 16'd0;
            else if (r < 60) width_val = CFG_DATA_W'($urandom_range(1, 8));
            else if (r < 85) width_val = CFG_DATA_W'($urandom_range(9, 24));
            else if (r < 94) width_val = CFG_DATA_W'($urandom_range(25, 64));
            else if (r < 97) width_val = 16'hFFFF;
            else             width_val = CFG_DATA_W'(MAX_WIDTH);
            r = $urandom_range(0, 99);
            if (r < 5)       height_val = 16'd0;
            else if (r < 60) height_val = CFG_DATA_W'($urandom_range(1, 4));
            else if (r < 85) height_val = CFG_DATA_W'($urandom_range(5, 12));
            else if (r < 95) height_val = 16'hFFFF;
            else             height_val = CFG_DATA_W'($urandom_range(0, 65535));
            if ($urandom_range(0, 1) == 0) begin
                write_reg(CFG_IMAGE_WIDTH, width_val);
                write_reg(CFG_IMAGE_HEIGHT, height_val);
            end else begin
                write_reg(CFG_IMAGE_HEIGHT, height_val);
                write_reg(CFG_IMAGE_WIDTH, width_val);
            end

            if (first_phase) begin
                send_pace         = PACE_FREE;
                recv_hold_request = LONG_HOLD;
                phase_items       = 80;
                first_phase       = 1'b0;
            end else begin
                send_pace   = t_pace'($urandom_range(0, 2));
                phase_items = (sb.active_width() > 64) ? 40 : $urandom_range(30, 110);
            end
            repeat (phase_items) send_rgb(pick_level(), pick_level(), pick_level());
            random_items += phase_items;
        end

        // Finish the current row at a width of 128 as a one-row frame, then
        // send a few pixels of the next frame to see that the stores were
        // cleared. A column already past the width ends the row at once.
        drain_outputs();
        write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'(TAIL_WIDTH));
        write_reg(CFG_IMAGE_HEIGHT, 16'd1);
        send_pace = PACE_LIGHT;
        if (sb.column < TAIL_WIDTH) tail_items = TAIL_WIDTH - sb.column + 8;
        else                        tail_items = 9;
        repeat (tail_items) send_rgb(pick_level(), pick_level(), pick_level());

        drain_outputs();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (sb.failures == 0 && sb.pending_words.size() == 0) begin
            $display("error_diffusion_dither_rgb555_top regression: pass");
        end else begin
            $display("error_diffusion_dither_rgb555_top regression: fail");
        end
        $finish;
    end

endmodule

[error_diffusion_dither_rgb555_top.f]
+incdir+rtl
rtl/edd_pkg.sv
rtl/edd_ram.sv
rtl/edd_chan.sv
rtl/edd_outq.sv
rtl/error_diffusion_dither_rgb555_top.sv
dv/edd_tb_pkg.sv
dv/tb.sv
